@@ rtl/ray_box_slab_hit_with_normals_assert.svh @@
// Assertion macros shared by the ray versus box slab test RTL.
// Depends on nothing; included by the files that check their own logic.
`ifndef RAY_BOX_SLAB_HIT_WITH_NORMALS_ASSERT_SVH
`define RAY_BOX_SLAB_HIT_WITH_NORMALS_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RBSH_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rbsh: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define RBSH_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rbsh: next-cycle check failed");

`endif

@@ rtl/rbsh_pkg.sv @@
// Package for the ray versus box slab test: register indexes, face codes,
// saturation limits and the side-band word that travels down the pipeline.
// Depends on nothing.
package rbsh_pkg;

   localparam int FRAC_BITS_DEF = 16;
   localparam int AXES          = 3;
   localparam int LANES         = 2 * AXES;

   localparam logic [2:0] REG_CENTER_X = 3'd0;
   localparam logic [2:0] REG_CENTER_Y = 3'd1;
   localparam logic [2:0] REG_CENTER_Z = 3'd2;
   localparam logic [2:0] REG_HALF_X   = 3'd3;
   localparam logic [2:0] REG_HALF_Y   = 3'd4;
   localparam logic [2:0] REG_HALF_Z   = 3'd5;
   localparam logic [2:0] REG_EPSILON  = 3'd6;

   localparam logic [2:0] FACE_NONE  = 3'd0;
   localparam logic [2:0] FACE_POS_X = 3'd1;
   localparam logic [2:0] FACE_NEG_X = 3'd2;
   localparam logic [2:0] FACE_POS_Y = 3'd3;
   localparam logic [2:0] FACE_NEG_Y = 3'd4;
   localparam logic [2:0] FACE_POS_Z = 3'd5;
   localparam logic [2:0] FACE_NEG_Z = 3'd6;

   localparam logic [2:0] FACE_POS [AXES] = '{FACE_POS_X, FACE_POS_Y, FACE_POS_Z};
   localparam logic [2:0] FACE_NEG [AXES] = '{FACE_NEG_X, FACE_NEG_Y, FACE_NEG_Z};

   localparam logic signed [31:0] SAT_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

   localparam logic [30:0] HALF_RESET = 31'd65536;
   localparam logic [15:0] EPS_RESET  = 16'd1;

   typedef struct packed {
      logic [AXES-1:0][31:0] org;
      logic [AXES-1:0][31:0] dir;
      logic [AXES-1:0][2:0]  face;
      logic [AXES-1:0]       parl;
      logic                  rej;
   } side_type;

endpackage

@@ rtl/ray_box_slab_hit_with_normals.sv @@
// Ray versus axis-aligned box slab test with face normals, fully pipelined.
// Depends on rbsh_pkg and on ray_box_slab_hit_with_normals_assert.svh.

// One ray word is taken every cycle while the output is not stalled, and
// its result word leaves through stages A and B, the divider load, the
// divider and stages D to H. Most of the pipeline depth is in the six slab
// dividers, each a restoring divider that settles one quotient bit per
// pipeline stage over 33 + FRAC_BITS stages. The whole pipeline advances
// together; it halts only while a finished result word waits at the output and is not taken.
`include "ray_box_slab_hit_with_normals_assert.svh"

module ray_box_slab_hit_with_normals
   import rbsh_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [31:0] req_origin_x,
   input  logic signed [31:0] req_origin_y,
   input  logic signed [31:0] req_origin_z,
   input  logic signed [31:0] req_dir_x,
   input  logic signed [31:0] req_dir_y,
   input  logic signed [31:0] req_dir_z,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_hit,
   output logic signed [31:0] rsp_near_distance,
   output logic signed [31:0] rsp_far_distance,
   output logic [2:0]         rsp_near_face,
   output logic [2:0]         rsp_far_face,
   output logic signed [31:0] rsp_near_point_x,
   output logic signed [31:0] rsp_near_point_y,
   output logic signed [31:0] rsp_near_point_z,
   output logic signed [31:0] rsp_far_point_x,
   output logic signed [31:0] rsp_far_point_y,
   output logic signed [31:0] rsp_far_point_z,
   input  logic               csr_we,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_wdata
);

   localparam int NW   = 33 + FRAC_BITS;
   localparam int QW   = NW + 1;
   localparam int NSTG = NW + 7;

   logic en;
   logic [NSTG-1:0] pvld_ff;

   logic signed [31:0] center_ff [AXES];
   logic [30:0]        half_ff [AXES];
   logic [15:0]        eps_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < AXES; i++) begin
            center_ff[i] <= '0;
            half_ff[i]   <= HALF_RESET;
         end
         eps_ff <= EPS_RESET;
      end else if (csr_we) begin
         case (csr_index)
            REG_CENTER_X: center_ff[0] <= csr_wdata;
            REG_CENTER_Y: center_ff[1] <= csr_wdata;
            REG_CENTER_Z: center_ff[2] <= csr_wdata;
            REG_HALF_X:   half_ff[0]   <= csr_wdata[30:0];
            REG_HALF_Y:   half_ff[1]   <= csr_wdata[30:0];
            REG_HALF_Z:   half_ff[2]   <= csr_wdata[30:0];
            REG_EPSILON:  eps_ff       <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   logic rsp_valid_ff;
   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         pvld_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         pvld_ff      <= {pvld_ff[NSTG-2:0], req_valid};
         rsp_valid_ff <= pvld_ff[NSTG-1];
      end
   end

   // Stage A: offset from origin to centre and direction magnitude.
   logic signed [31:0] in_org [AXES];
   logic signed [31:0] in_dir [AXES];
   assign in_org[0] = req_origin_x;
   assign in_org[1] = req_origin_y;
   assign in_org[2] = req_origin_z;
   assign in_dir[0] = req_dir_x;
   assign in_dir[1] = req_dir_y;
   assign in_dir[2] = req_dir_z;

   logic [32:0] a_par_in [AXES];
   logic [32:0] a_par_ff [AXES];
   logic [31:0] a_dmag_in [AXES];
   logic [31:0] a_dmag_ff [AXES];
   side_type    a_side_in, a_side_ff;

   always_comb begin
      a_side_in = '0;
      for (int i = 0; i < AXES; i++) begin
         a_par_in[i]  = {center_ff[i][31], center_ff[i]} - {in_org[i][31], in_org[i]};
         a_dmag_in[i] = in_dir[i][31] ? (~in_dir[i] + 32'd1) : in_dir[i];
         a_side_in.org[i] = in_org[i];
         a_side_in.dir[i] = in_dir[i];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_par_ff  <= a_par_in;
         a_dmag_ff <= a_dmag_in;
         a_side_ff <= a_side_in;
      end
   end

   // Stage B: slab numerators, parallel test and face selection.
   logic [33:0] b_num_in [LANES];
   logic [33:0] b_num_ff [LANES];
   logic [31:0] b_dmag_ff [AXES];
   logic        b_out [AXES];
   side_type    b_side_in, b_side_ff;

   always_comb begin
      b_side_in     = a_side_ff;
      b_side_in.rej = 1'b0;
      for (int i = 0; i < AXES; i++) begin
         b_num_in[2*i]   = {a_par_ff[i][32], a_par_ff[i]} + {3'b000, half_ff[i]};
         b_num_in[2*i+1] = {a_par_ff[i][32], a_par_ff[i]} - {3'b000, half_ff[i]};
         b_side_in.parl[i] = (a_dmag_ff[i] == '0) || (a_dmag_ff[i] < {16'h0000, eps_ff});
         b_side_in.face[i] = a_par_ff[i][32] ? FACE_POS[i] :
                             (a_par_ff[i] != '0) ? FACE_NEG[i] : FACE_NONE;
         b_out[i] = b_num_in[2*i][33] ||
                    (!b_num_in[2*i+1][33] && (b_num_in[2*i+1] != '0));
         b_side_in.rej = b_side_in.rej || (b_side_in.parl[i] && b_out[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         b_num_ff  <= b_num_in;
         b_dmag_ff <= a_dmag_ff;
         b_side_ff <= b_side_in;
      end
   end

   // Divider pipeline: stage 0 is loaded here, each later stage adds one bit.
   logic [31:0]      rem_ff  [0:NW][LANES];
   logic [NW-1:0]    dq_ff   [0:NW][LANES];
   logic [31:0]      den_ff  [0:NW][AXES];
   logic [LANES-1:0] neg_ff  [0:NW];
   side_type         side_ff [0:NW];

   logic [33:0]      c_nmag [LANES];
   logic [LANES-1:0] c_neg;

   always_comb begin
      for (int j = 0; j < LANES; j++) begin
         c_nmag[j] = b_num_ff[j][33] ? (~b_num_ff[j] + 34'd1) : b_num_ff[j];
         c_neg[j]  = b_num_ff[j][33] ^ b_side_ff.dir[j/2][31];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int j = 0; j < LANES; j++) begin
            rem_ff[0][j] <= '0;
            dq_ff[0][j]  <= {c_nmag[j][32:0], {FRAC_BITS{1'b0}}};
         end
         den_ff[0]  <= b_dmag_ff;
         neg_ff[0]  <= c_neg;
         side_ff[0] <= b_side_ff;
      end
   end

   for (genvar k = 0; k < NW; k++) begin : g_div
      for (genvar j = 0; j < LANES; j++) begin : g_lane
         logic [32:0] trial;
         logic [32:0] diff;
         logic        ge;
         assign trial = {rem_ff[k][j], dq_ff[k][j][NW-1]};
         assign diff  = trial - {1'b0, den_ff[k][j/2]};
         assign ge    = trial >= {1'b0, den_ff[k][j/2]};
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[k+1][j] <= ge ? diff[31:0] : trial[31:0];
               dq_ff[k+1][j]  <= {dq_ff[k][j][NW-2:0], ge};
            end
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            den_ff[k+1]  <= den_ff[k];
            neg_ff[k+1]  <= neg_ff[k];
            side_ff[k+1] <= side_ff[k];
         end
      end
   end

   // Stage D: signed quotients, ordered into entry and exit per axis.
   logic signed [QW-1:0] d_q [LANES];
   logic signed [QW-1:0] d_lo_in [AXES];
   logic signed [QW-1:0] d_hi_in [AXES];
   logic signed [QW-1:0] d_lo_ff [AXES];
   logic signed [QW-1:0] d_hi_ff [AXES];
   side_type             d_side_ff;

   always_comb begin
      for (int j = 0; j < LANES; j++) begin
         d_q[j] = neg_ff[NW][j] ? -$signed({1'b0, dq_ff[NW][j]})
                                :  $signed({1'b0, dq_ff[NW][j]});
      end
      for (int i = 0; i < AXES; i++) begin
         if (d_q[2*i] > d_q[2*i+1]) begin
            d_lo_in[i] = d_q[2*i+1];
            d_hi_in[i] = d_q[2*i];
         end else begin
            d_lo_in[i] = d_q[2*i];
            d_hi_in[i] = d_q[2*i+1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d_lo_ff   <= d_lo_in;
         d_hi_ff   <= d_hi_in;
         d_side_ff <= side_ff[NW];
      end
   end

   // Stage E: largest entry and smallest exit over the non-parallel axes, in axis order.
   logic signed [QW-1:0] e_tn_in, e_tf_in, e_tn_ff, e_tf_ff;
   logic                 e_set_in, e_set_ff;
   logic [2:0]           e_nface_in, e_fface_in, e_nface_ff, e_fface_ff;
   side_type             e_side_ff;

   always_comb begin
      e_tn_in    = '0;
      e_tf_in    = '0;
      e_set_in   = 1'b0;
      e_nface_in = FACE_NONE;
      e_fface_in = FACE_NONE;
      for (int i = 0; i < AXES; i++) begin
         if (!d_side_ff.parl[i]) begin
            if (!e_set_in || (d_lo_ff[i] > e_tn_in)) begin
               e_tn_in    = d_lo_ff[i];
               e_nface_in = d_side_ff.face[i];
            end
            if (!e_set_in || (d_hi_ff[i] < e_tf_in)) begin
               e_tf_in    = d_hi_ff[i];
               e_fface_in = d_side_ff.face[i];
            end
            e_set_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         e_tn_ff    <= e_tn_in;
         e_tf_ff    <= e_tf_in;
         e_set_ff   <= e_set_in;
         e_nface_ff <= e_nface_in;
         e_fface_ff <= e_fface_in;
         e_side_ff  <= d_side_ff;
      end
   end

   // Stage F: hit decision, swap flag and saturated distances.
   logic               f_hit_in, f_swap_in, f_hit_ff, f_swap_ff;
   logic signed [31:0] f_dn_in, f_df_in, f_dn_ff, f_df_ff;
   logic [2:0]         f_nface_ff, f_fface_ff;
   side_type           f_side_ff;

   always_comb begin
      f_hit_in  = !e_side_ff.rej &&
                  (!e_set_ff || ((e_tn_ff <= e_tf_ff) && !e_tf_ff[QW-1]));
      f_swap_in = !e_set_ff || e_tn_ff[QW-1];
      if (!e_set_ff) begin
         f_dn_in = SAT_MIN;
         f_df_in = SAT_MAX;
      end else begin
         f_dn_in = (e_tn_ff > QW'(SAT_MAX)) ? SAT_MAX :
                   (e_tn_ff < QW'(SAT_MIN)) ? SAT_MIN : e_tn_ff[31:0];
         f_df_in = (e_tf_ff > QW'(SAT_MAX)) ? SAT_MAX :
                   (e_tf_ff < QW'(SAT_MIN)) ? SAT_MIN : e_tf_ff[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         f_hit_ff   <= f_hit_in;
         f_swap_ff  <= f_swap_in;
         f_dn_ff    <= f_dn_in;
         f_df_ff    <= f_df_in;
         f_nface_ff <= e_nface_ff;
         f_fface_ff <= e_fface_ff;
         f_side_ff  <= e_side_ff;
      end
   end

   // Stage G: distance times direction for each point coordinate.
   logic signed [63:0] g_pn_in [AXES];
   logic signed [63:0] g_pf_in [AXES];
   logic signed [63:0] g_pn_ff [AXES];
   logic signed [63:0] g_pf_ff [AXES];
   logic signed [31:0] g_org_ff [AXES];
   logic signed [31:0] g_dn_ff, g_df_ff;
   logic [2:0]         g_nface_ff, g_fface_ff;
   logic               g_hit_ff, g_swap_ff;

   always_comb begin
      for (int i = 0; i < AXES; i++) begin
         g_pn_in[i] = f_dn_ff * $signed(f_side_ff.dir[i]);
         g_pf_in[i] = f_df_ff * $signed(f_side_ff.dir[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         g_pn_ff <= g_pn_in;
         g_pf_ff <= g_pf_in;
         for (int i = 0; i < AXES; i++) begin
            g_org_ff[i] <= f_side_ff.org[i];
         end
         g_dn_ff    <= f_dn_ff;
         g_df_ff    <= f_df_ff;
         g_nface_ff <= f_nface_ff;
         g_fface_ff <= f_fface_ff;
         g_hit_ff   <= f_hit_ff;
         g_swap_ff  <= f_swap_ff;
      end
   end

   // Stage H: points, swap for an origin inside the box, zero on a miss.
   logic signed [64:0] h_sn [AXES];
   logic signed [64:0] h_sf [AXES];
   logic signed [31:0] h_np [AXES];
   logic signed [31:0] h_fp [AXES];

   logic               rsp_hit_ff;
   logic signed [31:0] rsp_near_distance_ff, rsp_far_distance_ff;
   logic [2:0]         rsp_near_face_ff, rsp_far_face_ff;
   logic signed [31:0] rsp_np_ff [AXES];
   logic signed [31:0] rsp_fp_ff [AXES];

   always_comb begin
      for (int i = 0; i < AXES; i++) begin
         h_sn[i] = 65'(g_org_ff[i]) + 65'(g_pn_ff[i] >>> FRAC_BITS);
         h_sf[i] = 65'(g_org_ff[i]) + 65'(g_pf_ff[i] >>> FRAC_BITS);
         h_np[i] = (h_sn[i] > 65'(SAT_MAX)) ? SAT_MAX :
                   (h_sn[i] < 65'(SAT_MIN)) ? SAT_MIN : h_sn[i][31:0];
         h_fp[i] = (h_sf[i] > 65'(SAT_MAX)) ? SAT_MAX :
                   (h_sf[i] < 65'(SAT_MIN)) ? SAT_MIN : h_sf[i][31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_hit_ff <= g_hit_ff;
         if (!g_hit_ff) begin
            rsp_near_distance_ff <= '0;
            rsp_far_distance_ff  <= '0;
            rsp_near_face_ff     <= FACE_NONE;
            rsp_far_face_ff      <= FACE_NONE;
            for (int i = 0; i < AXES; i++) begin
               rsp_np_ff[i] <= '0;
               rsp_fp_ff[i] <= '0;
            end
         end else if (g_swap_ff) begin
            rsp_near_distance_ff <= g_df_ff;
            rsp_far_distance_ff  <= g_dn_ff;
            rsp_near_face_ff     <= g_fface_ff;
            rsp_far_face_ff      <= g_nface_ff;
            rsp_np_ff            <= h_fp;
            rsp_fp_ff            <= h_np;
         end else begin
            rsp_near_distance_ff <= g_dn_ff;
            rsp_far_distance_ff  <= g_df_ff;
            rsp_near_face_ff     <= g_nface_ff;
            rsp_far_face_ff      <= g_fface_ff;
            rsp_np_ff            <= h_np;
            rsp_fp_ff            <= h_fp;
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_hit           = rsp_hit_ff;
   assign rsp_near_distance = rsp_near_distance_ff;
   assign rsp_far_distance  = rsp_far_distance_ff;
   assign rsp_near_face     = rsp_near_face_ff;
   assign rsp_far_face      = rsp_far_face_ff;
   assign rsp_near_point_x  = rsp_np_ff[0];
   assign rsp_near_point_y  = rsp_np_ff[1];
   assign rsp_near_point_z  = rsp_np_ff[2];
   assign rsp_far_point_x   = rsp_fp_ff[0];
   assign rsp_far_point_y   = rsp_fp_ff[1];
   assign rsp_far_point_z   = rsp_fp_ff[2];

   `RBSH_ASSERT_SAME(a_miss_is_zero, clock, reset, rsp_valid_ff && !rsp_hit_ff, (rsp_near_distance_ff == '0) && (rsp_far_distance_ff == '0) && (rsp_near_face_ff == FACE_NONE) && (rsp_far_face_ff == FACE_NONE))
   `RBSH_ASSERT_SAME(a_hit_near_ahead, clock, reset, rsp_valid_ff && rsp_hit_ff, !rsp_near_distance_ff[31])
   `RBSH_ASSERT_NEXT(a_stall_holds, clock, reset, !en, $stable(pvld_ff) && $stable(rsp_valid_ff))

endmodule
